// ----- hdl/psc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the power sample conditioner: widths, register map, reset values,
// divider constants and the sequencer state type. No dependencies.
package psc_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CURRENT_GAIN = 3'd0,
      CSR_VOLTAGE_GAIN = 3'd1,
      CSR_FILTER_ALPHA = 3'd2,
      CSR_NOISE_FLOOR  = 3'd3,
      CSR_ZERO_RESET   = 3'd4,
      CSR_PANEL_MIN    = 3'd5,
      CSR_RATED_MV     = 3'd6
   } csr_addr_type;

   // register reset values
   localparam logic signed [23:0] RST_CURRENT_GAIN = 24'sd256;
   localparam logic [17:0]        RST_VOLTAGE_GAIN = 18'd65536;
   localparam logic [15:0]        RST_FILTER_ALPHA = 16'd6554;
   localparam logic [23:0]        RST_NOISE_FLOOR  = 24'd0;
   localparam logic [7:0]         RST_ZERO_RESET   = 8'd5;
   localparam logic [15:0]        RST_PANEL_MIN    = 16'd1000;
   localparam logic [15:0]        RST_RATED_MV     = 16'd6000;

   // shared multiplier
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // power / 1000: estimate with floor(2^40/1000), then fix up by remainder
   localparam int         DIV_CONST  = 1000;
   localparam logic [30:0] DIV_RECIP = 31'd1099511627;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BUS,
      ST_CUR,
      ST_XREG,
      ST_SEL,
      ST_DIFF,
      ST_MH,
      ST_ML,
      ST_STEP,
      ST_UPD,
      ST_PWR,
      ST_PMUL,
      ST_QMUL,
      ST_QM,
      ST_REM,
      ST_FIX,
      ST_DONE
   } psc_state_type;

endpackage

// ----- hdl/psc_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the power sample conditioner: request, response, CSR write.
// Depends on psc_pkg for the CSR port widths.
interface psc_req_if;
   logic               valid;
   logic               ready;
   logic               read_ok;
   logic [15:0]        raw_bus;
   logic signed [15:0] raw_shunt;
   logic signed [15:0] raw_current;

   modport source (output valid, read_ok, raw_bus, raw_shunt, raw_current, input ready);
   modport sink   (input valid, read_ok, raw_bus, raw_shunt, raw_current, output ready);
endinterface

interface psc_rsp_if;
   logic               valid;
   logic               ready;
   logic               meter_ok;
   logic [15:0]        bus_mv;
   logic signed [15:0] shunt_10uv;
   logic [23:0]        current_ua;
   logic [15:0]        effective_mv;
   logic [30:0]        power_uw;

   modport source (output valid, meter_ok, bus_mv, shunt_10uv, current_ua, effective_mv,
                   power_uw, input ready);
   modport sink   (input valid, meter_ok, bus_mv, shunt_10uv, current_ua, effective_mv,
                   power_uw, output ready);
endinterface

interface psc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [psc_pkg::CSR_ADDR_W-1:0]  addr;
   logic [psc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ----- hdl/psc_mul.sv -----
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
// Depends on psc_pkg for operand widths.
module psc_mul (
   input  logic                                clock,
   input  logic signed [psc_pkg::MUL_A_W-1:0]  op_a,
   input  logic signed [psc_pkg::MUL_B_W-1:0]  op_b,
   output logic signed [psc_pkg::PROD_W-1:0]   prod_ff
);
   import psc_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// ----- hdl/power_sample_conditioner.sv -----
`timescale 1ns / 1ps
// Power sample conditioner top level: sequencer, filter state, CSRs, response register.
// Depends on psc_pkg, psc_if (channel interfaces) and psc_mul.
//
// Usage
//   req_ch : one beat per set of raw monitor words (read_ok, bus, shunt, current).
//   rsp_ch : one beat per request: meter_ok, bus_mv, shunt_10uv, filtered current_ua,
//            effective_mv and power_uw. A failed read gives an all-zero beat.
//   csr_ch : register writes, addr = register index, always ready; write only when idle.
// Timing
//   Every multiply goes through one shared 33x32 multiplier under a sequencer, one
//   product per cycle. An item runs through more states when the moving average updates
//   than when the filter loads or clears; a failed read goes straight to the response.
//   req_ch.ready is high only while the sequencer is idle.
// Back pressure
//   The response sits in an output register; a new request is taken while it waits.
//   The sequencer only stalls in its final step if that register is still full.
// Reset
//   Synchronous, active high: CSRs return to their defaults, filter, load flag and zero
//   streak clear, no response is pending.
module power_sample_conditioner (
   input  logic   clock,
   input  logic   reset,
   psc_req_if.sink   req_ch,
   psc_rsp_if.source rsp_ch,
   psc_csr_if.sink   csr_ch
);
   import psc_pkg::*;

   // CSRs
   logic signed [23:0] cur_gain_ff;
   logic [17:0]        volt_gain_ff;
   logic [15:0]        alpha_ff;
   logic [23:0]        noise_ff;
   logic [7:0]         zrc_ff;
   logic [15:0]        panel_min_ff;
   logic [15:0]        rated_ff;

   psc_state_type state_ff, state_in;

   // latched request
   logic               ok_ff, ok_in;
   logic [12:0]        counts_ff, counts_in;
   logic signed [15:0] shunt_ff, shunt_in;
   logic signed [15:0] raw_cur_ff, raw_cur_in;

   // datapath
   logic [15:0]        bus_mv_ff, bus_mv_in;
   logic signed [39:0] x_ff, x_in;
   logic [15:0]        eff_mv_ff, eff_mv_in;
   logic [38:0]        t_ff, t_in;
   logic               neg_ff, neg_in;
   logic [38:0]        mag_ff, mag_in;
   logic [54:0]        acc_ff, acc_in;
   logic [38:0]        step_ff, step_in;
   logic [23:0]        cur_ua_ff, cur_ua_in;
   logic [39:0]        p_ff, p_in;
   logic [30:0]        q_ff, q_in;
   logic [11:0]        rem_ff, rem_in;
   logic [30:0]        power_ff, power_in;

   // filter state (Q8 microamps, never negative)
   logic [38:0]        f_ff, f_in;
   logic               loaded_ff, loaded_in;
   logic [7:0]         streak_ff, streak_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [15:0]        rsp_bus_ff, rsp_bus_in;
   logic signed [15:0] rsp_shunt_ff, rsp_shunt_in;
   logic [23:0]        rsp_cur_ff, rsp_cur_in;
   logic [15:0]        rsp_eff_ff, rsp_eff_in;
   logic [30:0]        rsp_pwr_ff, rsp_pwr_in;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff;

   // helpers
   logic               req_take;
   logic               rsp_free;
   logic [16:0]        bus_prod_mv;
   logic signed [39:0] x_floor;
   logic signed [39:0] x_clamp;
   logic               x_zero;
   logic [7:0]         streak_next;
   logic [39:0]        diff;
   logic [39:0]        diff_neg;
   logic [54:0]        step_sum;
   logic [38:0]        f_upd;
   logic [23:0]        cur_sat;
   logic [39:0]        rem_full;
   logic [30:0]        q_fix;

   psc_mul u_psc_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.meter_ok     = rsp_ok_ff;
   assign rsp_ch.bus_mv       = rsp_bus_ff;
   assign rsp_ch.shunt_10uv   = rsp_shunt_ff;
   assign rsp_ch.current_ua   = rsp_cur_ff;
   assign rsp_ch.effective_mv = rsp_eff_ff;
   assign rsp_ch.power_uw     = rsp_pwr_ff;

   // bus: counts*4*gain >> 16, product below 2^33
   assign bus_prod_mv = prod_ff[32:16];

   // noise floor in Q8; anything below reads as zero
   assign x_floor = $signed({8'b0, noise_ff, 8'b0});
   assign x_clamp = (x_ff < x_floor) ? 40'sd0 : x_ff;
   assign x_zero  = x_clamp[39] || (x_clamp == 40'sd0);

   assign streak_next = (streak_ff == 8'hFF) ? streak_ff : streak_ff + 8'd1;

   // filter step: |x - f| * alpha >> 16, split in a 19-bit upper and a 20-bit lower part
   assign diff     = {1'b0, t_ff} - {1'b0, f_ff};
   assign diff_neg = 40'd0 - diff;
   assign step_sum = acc_ff + {19'b0, prod_ff[35:0]};
   assign f_upd    = neg_ff ? (f_ff - step_ff) : (f_ff + step_ff);
   assign cur_sat  = (f_ff[38:32] != 7'd0) ? 24'hFFFFFF : f_ff[31:8];

   // quotient estimate is low by at most two
   assign rem_full = p_ff - prod_ff[39:0];
   assign q_fix    = q_ff + {30'b0, (rem_ff >= 12'(DIV_CONST))}
                          + {30'b0, (rem_ff >= 12'(2 * DIV_CONST))};

   always_comb begin
      state_in     = state_ff;
      ok_in        = ok_ff;
      counts_in    = counts_ff;
      shunt_in     = shunt_ff;
      raw_cur_in   = raw_cur_ff;
      bus_mv_in    = bus_mv_ff;
      x_in         = x_ff;
      eff_mv_in    = eff_mv_ff;
      t_in         = t_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      cur_ua_in    = cur_ua_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      power_in     = power_ff;
      f_in         = f_ff;
      loaded_in    = loaded_ff;
      streak_in    = streak_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_bus_in   = rsp_bus_ff;
      rsp_shunt_in = rsp_shunt_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_eff_in   = rsp_eff_ff;
      rsp_pwr_in   = rsp_pwr_ff;
      mul_a        = '0;
      mul_b        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               ok_in      = req_ch.read_ok;
               counts_in  = req_ch.raw_bus[15:3];
               shunt_in   = req_ch.raw_shunt;
               raw_cur_in = req_ch.raw_current;
               if (req_ch.read_ok) begin
                  state_in = ST_BUS;
               end else begin
                  f_in      = '0;
                  loaded_in = 1'b0;
                  streak_in = '0;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_BUS: begin
            mul_a    = {18'b0, counts_ff, 2'b00};
            mul_b    = {14'b0, volt_gain_ff};
            state_in = ST_CUR;
         end
         ST_CUR: begin
            bus_mv_in = bus_prod_mv[16] ? 16'hFFFF : bus_prod_mv[15:0];
            mul_a     = MUL_A_W'(raw_cur_ff);
            mul_b     = MUL_B_W'(cur_gain_ff);
            state_in  = ST_XREG;
         end
         ST_XREG: begin
            x_in      = prod_ff[39:0];
            eff_mv_in = (bus_mv_ff >= panel_min_ff) ? bus_mv_ff : rated_ff;
            state_in  = ST_SEL;
         end
         ST_SEL: begin
            if (x_zero) begin
               if (streak_next >= zrc_ff) begin
                  // zero streak long enough: drop the filter
                  f_in      = '0;
                  loaded_in = 1'b0;
                  streak_in = '0;
                  state_in  = ST_PWR;
               end else begin
                  streak_in = streak_next;
                  t_in      = '0;
                  if (!loaded_ff) begin
                     f_in      = '0;
                     loaded_in = 1'b1;
                     state_in  = ST_PWR;
                  end else begin
                     state_in = ST_DIFF;
                  end
               end
            end else begin
               streak_in = '0;
               t_in      = x_clamp[38:0];
               if (!loaded_ff) begin
                  f_in      = x_clamp[38:0];
                  loaded_in = 1'b1;
                  state_in  = ST_PWR;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            neg_in   = diff[39];
            mag_in   = diff[39] ? diff_neg[38:0] : diff[38:0];
            state_in = ST_MH;
         end
         ST_MH: begin
            mul_a    = {14'b0, mag_ff[38:20]};
            mul_b    = {16'b0, alpha_ff};
            state_in = ST_ML;
         end
         ST_ML: begin
            acc_in   = {prod_ff[34:0], 20'b0};
            mul_a    = {13'b0, mag_ff[19:0]};
            mul_b    = {16'b0, alpha_ff};
            state_in = ST_STEP;
         end
         ST_STEP: begin
            step_in  = step_sum[54:16];
            state_in = ST_UPD;
         end
         ST_UPD: begin
            f_in     = f_upd;
            state_in = ST_PWR;
         end
         ST_PWR: begin
            cur_ua_in = cur_sat;
            state_in  = ST_PMUL;
         end
         ST_PMUL: begin
            mul_a    = {17'b0, eff_mv_ff};
            mul_b    = {8'b0, cur_ua_ff};
            state_in = ST_QMUL;
         end
         ST_QMUL: begin
            p_in     = prod_ff[39:0];
            mul_a    = {1'b0, prod_ff[39:8]};
            mul_b    = {1'b0, DIV_RECIP};
            state_in = ST_QM;
         end
         ST_QM: begin
            q_in     = prod_ff[62:32];
            mul_a    = {2'b0, prod_ff[62:32]};
            mul_b    = MUL_B_W'(DIV_CONST);
            state_in = ST_REM;
         end
         ST_REM: begin
            rem_in   = rem_full[11:0];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            power_in = q_fix;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_bus_in   = ok_ff ? bus_mv_ff : 16'd0;
               rsp_shunt_in = ok_ff ? shunt_ff : 16'sd0;
               rsp_cur_in   = ok_ff ? cur_ua_ff : 24'd0;
               rsp_eff_in   = ok_ff ? eff_mv_ff : 16'd0;
               rsp_pwr_in   = ok_ff ? power_ff : 31'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff         <= '0;
         loaded_ff    <= 1'b0;
         streak_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         f_ff         <= f_in;
         loaded_ff    <= loaded_in;
         streak_ff    <= streak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      ok_ff        <= ok_in;
      counts_ff    <= counts_in;
      shunt_ff     <= shunt_in;
      raw_cur_ff   <= raw_cur_in;
      bus_mv_ff    <= bus_mv_in;
      x_ff         <= x_in;
      eff_mv_ff    <= eff_mv_in;
      t_ff         <= t_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      acc_ff       <= acc_in;
      step_ff      <= step_in;
      cur_ua_ff    <= cur_ua_in;
      p_ff         <= p_in;
      q_ff         <= q_in;
      rem_ff       <= rem_in;
      power_ff     <= power_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_bus_ff   <= rsp_bus_in;
      rsp_shunt_ff <= rsp_shunt_in;
      rsp_cur_ff   <= rsp_cur_in;
      rsp_eff_ff   <= rsp_eff_in;
      rsp_pwr_ff   <= rsp_pwr_in;
   end

   // CSR writes; unused addresses are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_gain_ff  <= RST_CURRENT_GAIN;
         volt_gain_ff <= RST_VOLTAGE_GAIN;
         alpha_ff     <= RST_FILTER_ALPHA;
         noise_ff     <= RST_NOISE_FLOOR;
         zrc_ff       <= RST_ZERO_RESET;
         panel_min_ff <= RST_PANEL_MIN;
         rated_ff     <= RST_RATED_MV;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.addr)
            CSR_CURRENT_GAIN: cur_gain_ff  <= $signed(csr_ch.data[23:0]);
            CSR_VOLTAGE_GAIN: volt_gain_ff <= csr_ch.data[17:0];
            CSR_FILTER_ALPHA: alpha_ff     <= csr_ch.data[15:0];
            CSR_NOISE_FLOOR:  noise_ff     <= csr_ch.data[23:0];
            CSR_ZERO_RESET:   zrc_ff       <= csr_ch.data[7:0];
            CSR_PANEL_MIN:    panel_min_ff <= csr_ch.data[15:0];
            CSR_RATED_MV:     rated_ff     <= csr_ch.data[15:0];
            default: begin
            end
         endcase
      end
   end
endmodule

// ----- hdl/psc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the power sample conditioner, bound to the top level.
// Depends on the top level's channel interfaces through the bind connections.
module psc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        meter_ok,
   input logic [15:0] bus_mv,
   input logic [15:0] shunt_10uv,
   input logic [23:0] current_ua,
   input logic [15:0] effective_mv,
   input logic [30:0] power_uw
);

   // one item in flight: busy right after a request beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous item in progress");

   // failed read gives an all-zero beat
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !meter_ok) |-> (bus_mv == 16'd0 && shunt_10uv == 16'd0 &&
         current_ua == 24'd0 && effective_mv == 16'd0 && power_uw == 31'd0))
      else $error("nonzero field on failed read");

   // no current means no power
   a_zero_power: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && current_ua == 24'd0) |-> (power_uw == 31'd0))
      else $error("power without current");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(meter_ok) && $stable(bus_mv) &&
         $stable(current_ua) && $stable(power_uw) && $stable(effective_mv)))
      else $error("response changed while stalled");

endmodule

bind power_sample_conditioner psc_checker u_psc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .meter_ok     (rsp_ch.meter_ok),
   .bus_mv       (rsp_ch.bus_mv),
   .shunt_10uv   (rsp_ch.shunt_10uv),
   .current_ua   (rsp_ch.current_ua),
   .effective_mv (rsp_ch.effective_mv),
   .power_uw     (rsp_ch.power_uw)
);
